/* rtl/core/bda_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bda_pkg
// Shared types and constants for the block-average downsampler.
// ----------------------------------------------------------------------------
package bda_pkg;

    // default sizing of the column store and block counters
    localparam int DEF_MAX_WIDTH = 4096;
    localparam int DEF_MAX_BLOCK = 64;
    localparam int MAX_HEIGHT    = 4096;
    localparam int ROW_W         = $clog2(MAX_HEIGHT);

    // quotient bits of one averaged channel
    localparam int QUOT_W    = 8;
    localparam int DIV_STEPS = QUOT_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // configuration register widths and indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int BSZ_W      = 7;
    localparam int DIM_W      = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

    localparam logic [BSZ_W-1:0] RST_BLOCK_SIZE   = 7'd30;
    localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = 13'd1920;
    localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = 13'd1080;

    // pixel payload
    localparam int CHAN_W = 8;
    localparam int PIX_W  = 3 * CHAN_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_DIVIDE,
        ST_LOAD
    } bda_state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic accum;
        logic div_step;
        logic load_out;
    } bda_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic emit;
        logic out_busy;
    } bda_status_t;

endpackage

/* rtl/core/bda_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bda_div
// Restoring divider for one channel, one quotient bit per step, MSB first.
// ----------------------------------------------------------------------------
module bda_div #(
    parameter int SUM_W  = 20,
    parameter int AREA_W = 13
) (
    input  logic                       aclk,
    input  logic                       load,
    input  logic                       step,
    input  logic [SUM_W-1:0]           dividend,
    input  logic [AREA_W-1:0]          divisor,
    output logic [bda_pkg::QUOT_W-1:0] quot
);
    import bda_pkg::*;

    localparam int DW = AREA_W + QUOT_W;

    logic [DW-1:0]     rem_reg, rem_next;
    logic [DW-1:0]     dv_reg, dv_next;
    logic [QUOT_W-1:0] q_reg, q_next;

    // one compare/subtract per step
    always_comb begin
        rem_next = rem_reg;
        dv_next  = dv_reg;
        q_next   = q_reg;
        if (load) begin
            rem_next = DW'(dividend);
            dv_next  = DW'(divisor) << (QUOT_W - 1);
            q_next   = '0;
        end else if (step) begin
            if (rem_reg >= dv_reg) begin
                rem_next = rem_reg - dv_reg;
                q_next   = {q_reg[QUOT_W-2:0], 1'b1};
            end else begin
                q_next   = {q_reg[QUOT_W-2:0], 1'b0};
            end
            dv_next = dv_reg >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dv_reg  <= dv_next;
        q_reg   <= q_next;
    end

    assign quot = q_reg;

endmodule

/* rtl/core/bda_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bda_ctrl
// Sequencer: accept a pixel, accumulate, divide at block end, load result.
// ----------------------------------------------------------------------------
module bda_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  bda_pkg::bda_status_t status,
    output bda_pkg::bda_cmd_t    cmd
);
    import bda_pkg::*;

    bda_state_t        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    // state and step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM: begin
                cmd.accum  = 1'b1;
                step_next  = '0;
                state_next = status.emit ? ST_DIVIDE : ST_IDLE;
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                    step_next  = '0;
                    state_next = ST_LOAD;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_LOAD: begin
                if (!status.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

/* rtl/core/bda_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bda_datapath
// Config registers, raster counters, column-sum memory, dividers, output reg.
// ----------------------------------------------------------------------------
module bda_datapath #(
    parameter int MAX_WIDTH = bda_pkg::DEF_MAX_WIDTH,
    parameter int MAX_BLOCK = bda_pkg::DEF_MAX_BLOCK
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    input  logic [bda_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bda_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [bda_pkg::PIX_W-1:0]      s_tdata,
    input  logic                           m_tready,
    input  bda_pkg::bda_cmd_t              cmd,
    output bda_pkg::bda_status_t           status,
    output logic                           m_tvalid,
    output logic [bda_pkg::PIX_W-1:0]      m_tdata,
    output logic                           m_tlast,
    output logic                           m_tuser
);
    import bda_pkg::*;

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int WW     = CW + 1;
    localparam int NW     = $clog2(MAX_BLOCK + 1);
    localparam int SBW    = $clog2(MAX_BLOCK);
    localparam int AREA_W = $clog2(MAX_BLOCK * MAX_BLOCK + 1);
    localparam int SUM_W  = $clog2(255 * MAX_BLOCK * MAX_BLOCK + 1);
    localparam int HW     = ROW_W + 1;

    // configuration registers
    logic [BSZ_W-1:0] bsz_reg;
    logic [DIM_W-1:0] wid_reg, hgt_reg;
    logic             cfg_hit;

    always_comb begin
        cfg_hit = 1'b0;
        unique case (cfg_index)
            CFG_BLOCK_SIZE, CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT: cfg_hit = cfg_valid;
            default: cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bsz_reg <= RST_BLOCK_SIZE;
            wid_reg <= RST_IMAGE_WIDTH;
            hgt_reg <= RST_IMAGE_HEIGHT;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_BLOCK_SIZE:   bsz_reg <= cfg_data[BSZ_W-1:0];
                CFG_IMAGE_WIDTH:  wid_reg <= cfg_data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT: hgt_reg <= cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // clamped sizes
    logic [NW-1:0] n_c;
    logic [WW-1:0] w_c;
    logic [HW-1:0] h_c;

    always_comb begin
        if (bsz_reg == '0)                    n_c = NW'(1);
        else if (32'(bsz_reg) > MAX_BLOCK)    n_c = NW'(MAX_BLOCK);
        else                                  n_c = NW'(bsz_reg);
        if (wid_reg == '0)                    w_c = WW'(1);
        else if (32'(wid_reg) > MAX_WIDTH)    w_c = WW'(MAX_WIDTH);
        else                                  w_c = WW'(wid_reg);
        if (hgt_reg == '0)                    h_c = HW'(1);
        else if (32'(hgt_reg) > MAX_HEIGHT)   h_c = HW'(MAX_HEIGHT);
        else                                  h_c = HW'(hgt_reg);
    end

    // block area, registered ahead of the divider
    logic [AREA_W-1:0] area_reg;
    always_ff @(posedge aclk) begin
        area_reg <= AREA_W'(32'(n_c) * 32'(n_c));
    end

    // raster position counters
    logic [CW-1:0]    pcol_reg, pcol_next, ocol_reg, ocol_next;
    logic [ROW_W-1:0] prow_reg, prow_next;
    logic [SBW-1:0]   scol_reg, scol_next, srow_reg, srow_next;
    logic             col_wrap, row_wrap, scol_last, srow_last;
    logic             rend, fend;

    assign col_wrap  = 32'(pcol_reg) >= 32'(w_c) - 1;
    assign row_wrap  = 32'(prow_reg) >= 32'(h_c) - 1;
    assign scol_last = 32'(scol_reg) >= 32'(n_c) - 1;
    assign srow_last = 32'(srow_reg) >= 32'(n_c) - 1;
    assign rend      = (32'(pcol_reg) + 1 + 32'(n_c)) > 32'(w_c);
    assign fend      = rend && ((32'(prow_reg) + 1 + 32'(n_c)) > 32'(h_c));

    always_comb begin
        pcol_next = pcol_reg;
        prow_next = prow_reg;
        scol_next = scol_reg;
        srow_next = srow_reg;
        ocol_next = ocol_reg;
        if (cfg_hit) begin
            pcol_next = '0;
            prow_next = '0;
            scol_next = '0;
            srow_next = '0;
            ocol_next = '0;
        end else if (cmd.accept) begin
            if (col_wrap) begin
                pcol_next = '0;
                scol_next = '0;
                ocol_next = '0;
                if (row_wrap) begin
                    prow_next = '0;
                    srow_next = '0;
                end else begin
                    prow_next = prow_reg + 1'b1;
                    srow_next = srow_last ? '0 : srow_reg + 1'b1;
                end
            end else begin
                pcol_next = pcol_reg + 1'b1;
                if (scol_last) begin
                    scol_next = '0;
                    ocol_next = ocol_reg + 1'b1;
                end else begin
                    scol_next = scol_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pcol_reg <= '0;
            prow_reg <= '0;
            scol_reg <= '0;
            srow_reg <= '0;
            ocol_reg <= '0;
        end else begin
            pcol_reg <= pcol_next;
            prow_reg <= prow_next;
            scol_reg <= scol_next;
            srow_reg <= srow_next;
            ocol_reg <= ocol_next;
        end
    end

    // per-pixel flags latched at accept
    logic [PIX_W-1:0] pix_reg;
    logic [CW-1:0]    widx_reg;
    logic             first_reg, emit_reg, rend_reg, fend_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            emit_reg <= 1'b0;
        end else if (cmd.accept) begin
            emit_reg <= scol_last && srow_last
                     && (32'(scol_reg) == 32'(n_c) - 1)
                     && (32'(srow_reg) == 32'(n_c) - 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            pix_reg   <= s_tdata;
            widx_reg  <= ocol_reg;
            first_reg <= (scol_reg == '0) && (srow_reg == '0);
            rend_reg  <= rend;
            fend_reg  <= fend;
        end
    end

    // column-sum memory: read at accept, write back on accumulate
    logic [3*SUM_W-1:0] mem [MAX_WIDTH];
    logic [3*SUM_W-1:0] rd_reg;
    logic [3*SUM_W-1:0] sum_next;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (first_reg)
                sum_next[c*SUM_W +: SUM_W] = SUM_W'(pix_reg[c*CHAN_W +: CHAN_W]);
            else
                sum_next[c*SUM_W +: SUM_W] = rd_reg[c*SUM_W +: SUM_W]
                                           + SUM_W'(pix_reg[c*CHAN_W +: CHAN_W]);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) rd_reg <= mem[ocol_reg];
        if (cmd.accum)  mem[widx_reg] <= sum_next;
    end

    // one divider lane per channel
    logic [QUOT_W-1:0] quot [3];

    for (genvar g = 0; g < 3; g++) begin : g_lane
        bda_div #(
            .SUM_W  (SUM_W),
            .AREA_W (AREA_W)
        ) u_div (
            .aclk     (aclk),
            .load     (cmd.accum),
            .step     (cmd.div_step),
            .dividend (sum_next[g*SUM_W +: SUM_W]),
            .divisor  (area_reg),
            .quot     (quot[g])
        );
    end

    // output register
    logic             out_valid_reg;
    logic [PIX_W-1:0] out_data_reg;
    logic             out_last_reg, out_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_data_reg <= {quot[2], quot[1], quot[0]};
            out_last_reg <= rend_reg;
            out_user_reg <= fend_reg;
        end
    end

    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = out_data_reg;
    assign m_tlast         = out_last_reg;
    assign m_tuser         = out_user_reg;
    assign status.emit     = emit_reg;
    assign status.out_busy = out_valid_reg && !m_tready;

endmodule

/* rtl/core/box_downsample_block_average_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_downsample_block_average_unit
// Averages each N x N block of a raster BGR stream into one output pixel.
// ----------------------------------------------------------------------------
// Input channel s_*: one pixel per transfer in raster order, blue in the low
// byte. Output channel m_*: one averaged pixel per completed block, tlast on
// the last block of an output row, tuser on the last block of the frame.
// Config channel cfg_*: index 0 block size, 1 image width, 2 image height;
// a write to any of these restarts the frame. Write only while the block is idle.
// A pixel that does not close a block is accepted and then accumulated by a
// read-modify-write of the column-sum memory, which has a single registered
// read port. A pixel that closes a block is accepted, accumulated, put through
// 8 restoring divide steps (one quotient bit each), and loaded into the output
// register, a load that waits while an earlier result is not yet taken; m_tvalid
// is set by that load. No new pixel is taken until the last one is through.
// The output register lets the next pixel be accepted while a result waits;
// if a second result is ready before the first is taken, the block holds in
// its load step and stops taking pixels until m_tready.
// Reset returns the counters to the frame start and the registers to
// 30 / 1920 / 1080. The column sums need no clearing: each entry is
// overwritten by the first pixel of a block, which ignores the value read.
// ----------------------------------------------------------------------------
module box_downsample_block_average_unit #(
    parameter int MAX_WIDTH = bda_pkg::DEF_MAX_WIDTH,
    parameter int MAX_BLOCK = bda_pkg::DEF_MAX_BLOCK
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input pixels
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bda_pkg::PIX_W-1:0]      s_tdata,   // blue, green, red
    // averaged pixels
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bda_pkg::PIX_W-1:0]      m_tdata,   // avg_blue, avg_green, avg_red
    output logic                           m_tlast,   // row_end
    output logic                           m_tuser,   // frame_end
    // configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bda_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bda_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bda_pkg::*;

    bda_cmd_t    cmd;
    bda_status_t status;

    assign cfg_ready = 1'b1;

    bda_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bda_datapath #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_BLOCK (MAX_BLOCK)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // one pixel in flight: no accept in the cycle after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("pixel accepted while previous one still in work");

    // a new result never overwrites one that has not been transferred
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_tvalid || m_tready))
        else $error("output register overwritten");

    // frame end always falls on a row end
    a_frame_on_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("frame_end without row_end");

endmodule
